// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the reassembler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define FPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define FPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fpr_pkg.sv =====
// Shared types and constants for the fast packet reassembler.
// No dependencies; imported by the interfaces and every module.
package fpr_pkg;

    localparam int unsigned NUM_LANES   = 7;
    localparam int unsigned FIRST_CHUNK = 6;
    localparam int unsigned CONT_CHUNK  = 7;
    localparam int unsigned MAX_INDEX   = 32;
    localparam logic [7:0]  CAPACITY_RESET = 8'd223;
    localparam logic [3:0]  MAX_FRAME_LEN  = 4'd8;

    typedef enum logic [1:0] {
        RX_OK      = 2'd0,
        RX_TIMEOUT = 2'd1,
        RX_ERROR   = 2'd2,
        RX_OTHER   = 2'd3
    } t_rx_status;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_PROTO    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_LINK     = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_RESERVED = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0] rx_status;
        logic [3:0] frame_len;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] offset;
        logic [2:0] count;
        logic [7:0] data_0;
        logic [7:0] data_1;
        logic [7:0] data_2;
        logic [7:0] data_3;
        logic [7:0] data_4;
        logic [7:0] data_5;
        logic [7:0] data_6;
    } t_out_item;

    // Per-frame decision handed from the control unit to the byte lanes
    typedef struct packed {
        logic [3:0] flen;    // clamped frame length
        logic       first;   // frame 0: data starts at byte 2
        logic [2:0] count;   // bytes to deliver
    } t_lane_ctl;

    typedef struct packed {
        t_status    status;
        logic [7:0] offset;
    } t_ctrl_res;

endpackage

// ===== hw/rtl/fpr_in_if.sv =====
// Input channel carrying one CAN frame per transaction.
// Depends on fpr_pkg.
interface fpr_in_if import fpr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/fpr_out_if.sv =====
// Output channel carrying one reassembly result per transaction.
// Depends on fpr_pkg.
interface fpr_out_if import fpr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/fpr_lane.sv =====
// One data byte lane: picks the frame byte for its output slot and masks it.
// Depends on fpr_pkg.
module fpr_lane import fpr_pkg::*; #(
    parameter int unsigned LANE_IDX = 0
) (
    input  t_lane_ctl  i_ctl,
    input  logic [7:0] i_byte_cont,   // frame byte LANE_IDX+1
    input  logic [7:0] i_byte_first,  // frame byte LANE_IDX+2
    output logic [7:0] o_data
);

    localparam logic [3:0] POS_CONT  = 4'(LANE_IDX + 1);
    localparam logic [3:0] POS_FIRST = 4'(LANE_IDX + 2);
    localparam logic [3:0] LANE_NUM  = 4'(LANE_IDX);

    logic [7:0] w_sel;

    always_comb begin
        if (i_ctl.first) begin
            w_sel = (POS_FIRST < i_ctl.flen) ? i_byte_first : 8'd0;
        end else begin
            w_sel = (POS_CONT < i_ctl.flen) ? i_byte_cont : 8'd0;
        end
        o_data = (LANE_NUM < {1'b0, i_ctl.count}) ? w_sel : 8'd0;
    end

endmodule

// ===== hw/rtl/fpr_ctrl.sv =====
// Message state and per-frame checks: sequence, index, length and capacity.
// Depends on fpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpr_ctrl import fpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_capacity,
    input  logic [1:0] i_rx_status,
    input  logic [3:0] i_frame_len,
    input  logic [7:0] i_byte_0,
    input  logic [7:0] i_byte_1,
    output t_lane_ctl  o_lane_ctl,
    output t_ctrl_res  o_res
);

    logic       r_busy;
    logic [2:0] r_seq;
    logic [5:0] r_exp;
    logic [7:0] r_total;
    logic [7:0] r_recv;

    logic       n_busy;
    logic [2:0] n_seq;
    logic [5:0] n_exp;
    logic [7:0] n_total;
    logic [7:0] n_recv;

    logic [3:0] w_flen;
    logic [3:0] w_flen_m1;
    logic [7:0] w_fr0;
    logic [7:0] w_fr1;
    logic [7:0] w_left;
    logic [2:0] w_cap7;
    logic [2:0] w_chunk;
    logic [7:0] w_recv_sum;

    always_comb begin
        w_flen     = (i_frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : i_frame_len;
        w_flen_m1  = w_flen - 4'd1;
        w_fr0      = (w_flen != 4'd0) ? i_byte_0 : 8'd0;
        w_fr1      = (w_flen > 4'd1) ? i_byte_1 : 8'd0;
        w_left     = (r_total > r_recv) ? (r_total - r_recv) : 8'd0;
        w_cap7     = (w_left < 8'(CONT_CHUNK)) ? w_left[2:0] : 3'(CONT_CHUNK);
        w_chunk    = (w_flen_m1[2:0] < w_cap7) ? w_flen_m1[2:0] : w_cap7;
        w_recv_sum = r_recv + {5'd0, w_chunk};
    end

    always_comb begin
        n_busy           = r_busy;
        n_seq            = r_seq;
        n_exp            = r_exp;
        n_total          = r_total;
        n_recv           = r_recv;
        o_res.status     = ST_PROTO;
        o_res.offset     = 8'd0;
        o_lane_ctl.flen  = w_flen;
        o_lane_ctl.first = !r_busy;
        o_lane_ctl.count = 3'd0;

        if (!r_busy) begin
            if (i_rx_status != RX_OK) begin
                o_res.status = (i_rx_status == RX_TIMEOUT) ? ST_TIMEOUT : ST_LINK;
            end else if (w_flen == 4'd0) begin
                o_res.status = ST_EMPTY;
            end else if (w_fr0[4:0] != 5'd0 || w_fr1 == 8'd0) begin
                o_res.status = ST_PROTO;
            end else if (w_fr1 > i_capacity) begin
                o_res.status = ST_OVERFLOW;
            end else if (w_fr1 <= 8'(FIRST_CHUNK)) begin
                o_res.status     = ST_COMPLETE;
                o_lane_ctl.count = w_fr1[2:0];
                n_exp            = 6'd0;
                n_recv           = 8'd0;
            end else begin
                o_res.status     = ST_PROGRESS;
                o_lane_ctl.count = 3'(FIRST_CHUNK);
                n_busy           = 1'b1;
                n_seq            = w_fr0[7:5];
                n_exp            = 6'd1;
                n_total          = w_fr1;
                n_recv           = 8'(FIRST_CHUNK);
            end
        end else begin
            if (i_rx_status != RX_OK || w_flen == 4'd0) begin
                o_res.status = (i_rx_status == RX_TIMEOUT) ? ST_TIMEOUT : ST_PROTO;
                n_busy       = 1'b0;
                n_exp        = 6'd0;
                n_recv       = 8'd0;
            end else if (w_fr0[7:5] != r_seq || {1'b0, w_fr0[4:0]} != r_exp) begin
                o_res.status = ST_PROTO;
                n_busy       = 1'b0;
                n_exp        = 6'd0;
                n_recv       = 8'd0;
            end else begin
                o_res.offset     = r_recv;
                o_lane_ctl.count = w_chunk;
                if (w_recv_sum >= r_total) begin
                    o_res.status = ST_COMPLETE;
                    n_busy       = 1'b0;
                    n_exp        = 6'd0;
                    n_recv       = 8'd0;
                end else begin
                    o_res.status = ST_PROGRESS;
                    n_recv       = w_recv_sum;
                    // saturate past the last 5-bit index so nothing matches
                    n_exp        = (r_exp < 6'(MAX_INDEX)) ? r_exp + 6'd1 : r_exp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_seq   <= 3'd0;
            r_exp   <= 6'd0;
            r_total <= 8'd0;
            r_recv  <= 8'd0;
        end else if (i_accept) begin
            r_busy  <= n_busy;
            r_seq   <= n_seq;
            r_exp   <= n_exp;
            r_total <= n_total;
            r_recv  <= n_recv;
        end
    end

    `FPR_ASSERT_NOW(a_busy_consistent, i_clk, i_rst_n, r_busy,
        (r_recv < r_total) && (r_exp != 6'd0) && (r_exp <= 6'(MAX_INDEX)),
        "busy with inconsistent byte count or index")
    `FPR_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n,
        i_accept && !r_busy && (o_res.status == ST_PROGRESS), r_busy && (r_recv == 8'(FIRST_CHUNK)),
        "message start did not enter busy")
    `FPR_ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n,
        i_accept && (o_res.status != ST_PROGRESS), !r_busy && (r_recv == 8'd0),
        "terminal result left the block busy")

endmodule

// ===== hw/rtl/fast_packet_reassembler.sv =====
// Fast packet reassembler: per-frame checks, seven byte lanes, result register.
// Depends on fpr_pkg, fpr_in_if, fpr_out_if, fpr_ctrl, fpr_lane, assert_macros.svh.
//
// Usage:
//   i_in carries one CAN frame per transaction (link status, byte count,
//   bytes 0..7). o_out returns exactly one result per frame: status, message
//   offset, byte count and up to seven payload bytes, zero beyond the count.
//   i_cfg_we/i_cfg_wdata write the capacity register; write it only while
//   no frame is in flight.
//   The result is registered: a frame accepted at a clock edge shows its result
//   in the cycle after. Throughput is one frame per cycle while the sink keeps
//   up; the control unit checks the frame and updates the message state on acceptance,
//   and the seven lanes select their bytes in parallel beside it.
//   A result waiting in the output register does not block input while the
//   sink takes it in the same cycle; if the sink stalls, the one held result
//   stays put and i_in.ready drops until it is taken.
//   Reset (synchronous, active low) empties the output register, returns
//   the reassembly state to idle and sets the capacity to 223.
`include "assert_macros.svh"

module fast_packet_reassembler import fpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    fpr_in_if.sink     i_in,
    fpr_out_if.source  o_out
);

    logic [7:0] r_capacity;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_accept;
    t_lane_ctl  w_lane_ctl;
    t_ctrl_res  w_res;
    logic [7:0] w_bytes [0:7];
    logic [7:0] w_data  [0:NUM_LANES-1];
    t_out_item  n_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_bytes[0] = i_in.payload.byte_0;
    assign w_bytes[1] = i_in.payload.byte_1;
    assign w_bytes[2] = i_in.payload.byte_2;
    assign w_bytes[3] = i_in.payload.byte_3;
    assign w_bytes[4] = i_in.payload.byte_4;
    assign w_bytes[5] = i_in.payload.byte_5;
    assign w_bytes[6] = i_in.payload.byte_6;
    assign w_bytes[7] = i_in.payload.byte_7;

    fpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_capacity  (r_capacity),
        .i_rx_status (i_in.payload.rx_status),
        .i_frame_len (i_in.payload.frame_len),
        .i_byte_0    (w_bytes[0]),
        .i_byte_1    (w_bytes[1]),
        .o_lane_ctl  (w_lane_ctl),
        .o_res       (w_res)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        if (g + 2 < 8) begin : g_full
            fpr_lane #(.LANE_IDX(g)) u_lane (
                .i_ctl        (w_lane_ctl),
                .i_byte_cont  (w_bytes[g + 1]),
                .i_byte_first (w_bytes[g + 2]),
                .o_data       (w_data[g])
            );
        end else begin : g_last
            // no frame byte beyond the eighth: frame 0 never fills this lane
            fpr_lane #(.LANE_IDX(g)) u_lane (
                .i_ctl        (w_lane_ctl),
                .i_byte_cont  (w_bytes[g + 1]),
                .i_byte_first (8'd0),
                .o_data       (w_data[g])
            );
        end
    end

    // Merge control result and lane bytes into one result
    always_comb begin
        n_out.status = w_res.status;
        n_out.offset = w_res.offset;
        n_out.count  = w_lane_ctl.count;
        n_out.data_0 = w_data[0];
        n_out.data_1 = w_data[1];
        n_out.data_2 = w_data[2];
        n_out.data_3 = w_data[3];
        n_out.data_4 = w_data[4];
        n_out.data_5 = w_data[5];
        n_out.data_6 = w_data[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `FPR_ASSERT_NOW(a_error_no_data, i_clk, i_rst_n,
        r_out_valid && (r_out.status != ST_PROGRESS) && (r_out.status != ST_COMPLETE),
        (r_out.count == 3'd0) && (r_out.offset == 8'd0),
        "error result carries data")
    `FPR_ASSERT_NEXT(a_accept_loads_result, i_clk, i_rst_n, w_accept,
        r_out_valid, "accepted frame produced no result")

endmodule
